[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions on clk with a low-active reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge, switched off while reset is held
`define QB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every rising edge, reset included
`define QB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/qbez_pkg.sv]
// ---------------------------------------------------------------------------
// qbez_pkg
// Widths, types and codes shared by the quadratic Bezier move generator.
// ---------------------------------------------------------------------------
`default_nettype none

package qbez_pkg;

    // Field widths
    localparam int COORD_W  = 24;
    localparam int TIME_W   = 24;
    localparam int FRAC_W   = 16;
    localparam int DELTA_W  = 16;
    localparam int NUM_AXES = 3;

    // Stream payload widths, rounded up to whole bytes
    localparam int S_DATA_W = ((6 * COORD_W + TIME_W + DELTA_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((NUM_AXES * COORD_W + 7) / 8) * 8;

    // Divider step counter and multiplier product widths
    localparam int DIV_CNT_W   = $clog2(FRAC_W + 1);
    localparam int LERP_PROD_W = COORD_W + FRAC_W + 2;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [TIME_W-1:0]         tick_t;
    typedef logic [FRAC_W-1:0]         frac_t;
    typedef logic [DELTA_W-1:0]        delta_t;

    // Command codes carried on s_tuser
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CTRL = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_LERP = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    // Interpolation steps within one axis
    typedef enum logic [1:0] {
        STEP_SC = 2'd0,
        STEP_CE = 2'd1,
        STEP_AB = 2'd2
    } step_t;

    localparam logic [1:0] AXIS_LAST = 2'(NUM_AXES - 1);

    // Result status of the divider
    typedef struct packed {
        logic  valid;
        frac_t quot;
    } div_res_t;

    // Result status of the interpolation unit
    typedef struct packed {
        logic   valid;
        coord_t value;
    } lerp_res_t;

endpackage

`default_nettype wire

[rtl/core/qbez_div.sv]
// ---------------------------------------------------------------------------
// qbez_div
// Restoring divider: quotient = floor(dividend * 2^FRAC_W / divisor),
// one quotient bit per cycle. Requires dividend < divisor.
// ---------------------------------------------------------------------------
`default_nettype none

module qbez_div
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire qbez_pkg::tick_t    dividend,
    input  wire qbez_pkg::tick_t    divisor,
    output qbez_pkg::div_res_t      res
);

    logic                              busy_reg;
    logic                              valid_reg;
    logic [qbez_pkg::DIV_CNT_W-1:0]    cnt_reg;
    qbez_pkg::tick_t                   rem_reg;
    qbez_pkg::tick_t                   dvsr_reg;
    qbez_pkg::frac_t                   quot_reg;

    logic [qbez_pkg::TIME_W:0]         rem_dbl;
    logic [qbez_pkg::TIME_W+1:0]       trial;
    logic                              fits;

    // Trial subtraction of the doubled remainder
    assign rem_dbl = {rem_reg, 1'b0};
    assign trial   = {1'b0, rem_dbl} - {2'b00, dvsr_reg};
    assign fits    = !trial[qbez_pkg::TIME_W+1];

    // Step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            valid_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= qbez_pkg::DIV_CNT_W'(qbez_pkg::FRAC_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == qbez_pkg::DIV_CNT_W'(1))
                begin
                    busy_reg  <= 1'b0;
                    valid_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= dividend;
            dvsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? trial[qbez_pkg::TIME_W-1:0] : rem_dbl[qbez_pkg::TIME_W-1:0];
            quot_reg <= {quot_reg[qbez_pkg::FRAC_W-2:0], fits};
        end
    end

    assign res.valid = valid_reg;
    assign res.quot  = quot_reg;

endmodule

`default_nettype wire

[rtl/core/qbez_lerp.sv]
// ---------------------------------------------------------------------------
// qbez_lerp
// Shared interpolation unit: p + round((q - p) * t / 2^FRAC_W), rounding
// half up. One signed multiply, registered, then the rounding add.
// ---------------------------------------------------------------------------
`default_nettype none

module qbez_lerp
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire qbez_pkg::coord_t   p,
    input  wire qbez_pkg::coord_t   q,
    input  wire qbez_pkg::frac_t    t,
    output qbez_pkg::lerp_res_t     res
);

    logic                                     phase_reg;
    logic                                     valid_reg;
    logic signed [qbez_pkg::LERP_PROD_W-1:0]  prod_reg;
    qbez_pkg::coord_t                         p_reg;
    qbez_pkg::coord_t                         res_reg;

    logic signed [qbez_pkg::COORD_W:0]        diff;
    logic signed [qbez_pkg::FRAC_W:0]         t_s;
    logic signed [qbez_pkg::LERP_PROD_W-1:0]  prod_next;
    logic signed [qbez_pkg::LERP_PROD_W-1:0]  half_c;
    logic signed [qbez_pkg::LERP_PROD_W-1:0]  rnd;
    logic signed [qbez_pkg::LERP_PROD_W-1:0]  scaled;

    // Multiply stage
    assign diff      = $signed({q[qbez_pkg::COORD_W-1], q}) - $signed({p[qbez_pkg::COORD_W-1], p});
    assign t_s       = $signed({1'b0, t});
    assign prod_next = qbez_pkg::LERP_PROD_W'(diff) * qbez_pkg::LERP_PROD_W'(t_s);

    // Rounding stage
    assign half_c = $signed(qbez_pkg::LERP_PROD_W'(1) << (qbez_pkg::FRAC_W - 1));
    assign rnd    = prod_reg + half_c;
    assign scaled = rnd >>> qbez_pkg::FRAC_W;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= start;
            valid_reg <= phase_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= prod_next;
            p_reg    <= p;
        end
        if (phase_reg)
        begin
            res_reg <= p_reg + scaled[qbez_pkg::COORD_W-1:0];
        end
    end

    assign res.valid = valid_reg;
    assign res.value = res_reg;

endmodule

`default_nettype wire

[rtl/core/quadratic_bezier_move_generator.sv]
// ---------------------------------------------------------------------------
// quadratic_bezier_move_generator
// 3D quadratic Bezier move generator in Q15.8 fixed point.
// ---------------------------------------------------------------------------
// A start beat (s_tuser = 0) latches start point, target and duration, derives
// the control point in the CTRL state and restarts any move; it produces no
// output. A tick beat (s_tuser = 1) on a running move with elapsed < duration
// produces one curve point: the restoring divider forms t = elapsed / duration,
// t is handed over, nine interpolations run through the single shared
// multiplier (three per axis), then the result register is loaded as the
// sequencer returns to idle for the next beat. A tick once the move has run its
// course returns the target with m_tlast set; a tick while no move runs is taken
// without leaving idle and produces nothing. Both kinds of result are held back
// only while the previous point still sits unaccepted in the result register.
// s_tready is low while a beat is being worked on; the result register lets the
// next beat in while a finished point still waits for m_tready.
// ---------------------------------------------------------------------------
`default_nettype none

module quadratic_bezier_move_generator
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // start_x, start_y, start_z, target_x, target_y, target_z, duration, delta_time
    input  wire logic [qbez_pkg::S_DATA_W-1:0]     s_tdata,
    // cmd
    input  wire logic [0:0]                        s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // pos_x, pos_y, pos_z
    output logic [qbez_pkg::M_DATA_W-1:0]          m_tdata,
    // done_res
    output logic                                   m_tlast
);

    localparam int CW = qbez_pkg::COORD_W;

    // Control registers
    qbez_pkg::state_t     state_reg, state_next;
    logic                 moving_reg, moving_next;
    qbez_pkg::tick_t      elapsed_reg, elapsed_next;
    qbez_pkg::tick_t      total_reg, total_next;
    logic                 lerp_go_reg, lerp_go_next;
    logic [1:0]           idx_reg, idx_next;
    qbez_pkg::step_t      step_reg, step_next;
    logic                 m_tvalid_reg, m_tvalid_next;

    // Payload registers
    qbez_pkg::coord_t     start_reg [qbez_pkg::NUM_AXES];
    qbez_pkg::coord_t     ctrl_reg  [qbez_pkg::NUM_AXES];
    qbez_pkg::coord_t     end_reg   [qbez_pkg::NUM_AXES];
    qbez_pkg::coord_t     pos_reg   [qbez_pkg::NUM_AXES];
    qbez_pkg::coord_t     a_reg;
    qbez_pkg::coord_t     b_reg;
    logic [CW-1:0]        half_reg;
    logic                 ahead_reg;
    qbez_pkg::delta_t     delta_reg;
    logic                 done_reg;
    qbez_pkg::frac_t      t_reg;
    logic [qbez_pkg::M_DATA_W-1:0] m_tdata_reg;
    logic                 m_tlast_reg;

    // Input fields and handshake decode
    qbez_pkg::coord_t     in_start  [qbez_pkg::NUM_AXES];
    qbez_pkg::coord_t     in_target [qbez_pkg::NUM_AXES];
    qbez_pkg::tick_t      in_duration;
    qbez_pkg::delta_t     in_delta;
    logic                 accept;
    logic                 start_acc;
    logic                 tick_acc;
    logic                 in_time;
    logic                 in_ahead;
    logic signed [CW:0]   in_xdiff;

    // Shared unit signals
    qbez_pkg::div_res_t   div_res;
    qbez_pkg::lerp_res_t  lerp_res;
    logic                 div_start;
    qbez_pkg::coord_t     op_p;
    qbez_pkg::coord_t     op_q;
    logic                 emit_fire;
    logic [qbez_pkg::TIME_W:0]         elapsed_sum;
    logic [qbez_pkg::M_DATA_W-1:0]     m_data_next;

    // Add or subtract a magnitude and clamp to the coordinate range
    function automatic qbez_pkg::coord_t sat_add(input qbez_pkg::coord_t base,
                                                 input logic [CW-1:0] mag,
                                                 input logic neg);
        logic signed [CW+1:0] sum;
        logic [2:0]           top;
        begin
            if (neg)
            begin
                sum = $signed({base[CW-1], base[CW-1], base}) - $signed({2'b00, mag});
            end
            else
            begin
                sum = $signed({base[CW-1], base[CW-1], base}) + $signed({2'b00, mag});
            end
            top = sum[CW+1:CW-1];
            if (top == 3'b000 || top == 3'b111)
            begin
                sat_add = sum[CW-1:0];
            end
            else if (sum[CW+1])
            begin
                sat_add = {1'b1, {(CW-1){1'b0}}};
            end
            else
            begin
                sat_add = {1'b0, {(CW-1){1'b1}}};
            end
        end
    endfunction

    // Unpack the input beat
    always_comb
    begin
        for (int k = 0; k < qbez_pkg::NUM_AXES; k++)
        begin
            in_start[k]  = s_tdata[k * CW +: CW];
            in_target[k] = s_tdata[(k + qbez_pkg::NUM_AXES) * CW +: CW];
        end
    end

    assign in_duration = s_tdata[6 * CW +: qbez_pkg::TIME_W];
    assign in_delta    = s_tdata[6 * CW + qbez_pkg::TIME_W +: qbez_pkg::DELTA_W];

    assign s_tready  = (state_reg == qbez_pkg::ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign start_acc = accept && (s_tuser[0] == qbez_pkg::CMD_START);
    assign tick_acc  = accept && (s_tuser[0] == qbez_pkg::CMD_TICK);
    assign in_time   = (elapsed_reg < total_reg);
    assign div_start = tick_acc && moving_reg && in_time;

    // Control point offset: half the X distance, sign from the X direction
    assign in_ahead = (in_target[0] > in_start[0]);
    assign in_xdiff = in_ahead
                    ? $signed({in_target[0][CW-1], in_target[0]})
                      - $signed({in_start[0][CW-1], in_start[0]})
                    : $signed({in_start[0][CW-1], in_start[0]})
                      - $signed({in_target[0][CW-1], in_target[0]});

    // Operand select for the shared interpolation unit
    always_comb
    begin
        case (step_reg)
            qbez_pkg::STEP_SC:
            begin
                op_p = start_reg[idx_reg];
                op_q = ctrl_reg[idx_reg];
            end
            qbez_pkg::STEP_CE:
            begin
                op_p = ctrl_reg[idx_reg];
                op_q = end_reg[idx_reg];
            end
            default:
            begin
                op_p = a_reg;
                op_q = b_reg;
            end
        endcase
    end

    qbez_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (elapsed_reg),
        .divisor  (total_reg),
        .res      (div_res)
    );

    qbez_lerp u_lerp
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (lerp_go_reg),
        .p     (op_p),
        .q     (op_q),
        .t     (t_reg),
        .res   (lerp_res)
    );

    assign emit_fire   = (state_reg == qbez_pkg::ST_EMIT) && (!m_tvalid_reg || m_tready);
    assign elapsed_sum = {1'b0, elapsed_reg} + (qbez_pkg::TIME_W + 1)'(delta_reg);

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        moving_next   = moving_reg;
        elapsed_next  = elapsed_reg;
        total_next    = total_reg;
        lerp_go_next  = 1'b0;
        idx_next      = idx_reg;
        step_next     = step_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        case (state_reg)
            qbez_pkg::ST_IDLE:
            begin
                if (start_acc)
                begin
                    total_next   = in_duration;
                    elapsed_next = '0;
                    moving_next  = 1'b1;
                    state_next   = qbez_pkg::ST_CTRL;
                end
                else if (tick_acc && moving_reg)
                begin
                    state_next = in_time ? qbez_pkg::ST_DIV : qbez_pkg::ST_EMIT;
                end
            end
            qbez_pkg::ST_CTRL:
            begin
                state_next = qbez_pkg::ST_IDLE;
            end
            qbez_pkg::ST_DIV:
            begin
                if (div_res.valid)
                begin
                    state_next   = qbez_pkg::ST_LERP;
                    lerp_go_next = 1'b1;
                    idx_next     = '0;
                    step_next    = qbez_pkg::STEP_SC;
                end
            end
            qbez_pkg::ST_LERP:
            begin
                if (lerp_res.valid)
                begin
                    case (step_reg)
                        qbez_pkg::STEP_SC:
                        begin
                            step_next    = qbez_pkg::STEP_CE;
                            lerp_go_next = 1'b1;
                        end
                        qbez_pkg::STEP_CE:
                        begin
                            step_next    = qbez_pkg::STEP_AB;
                            lerp_go_next = 1'b1;
                        end
                        default:
                        begin
                            if (idx_reg == qbez_pkg::AXIS_LAST)
                            begin
                                state_next = qbez_pkg::ST_EMIT;
                            end
                            else
                            begin
                                idx_next     = idx_reg + 1'b1;
                                step_next    = qbez_pkg::STEP_SC;
                                lerp_go_next = 1'b1;
                            end
                        end
                    endcase
                end
            end
            qbez_pkg::ST_EMIT:
            begin
                if (emit_fire)
                begin
                    m_tvalid_next = 1'b1;
                    state_next    = qbez_pkg::ST_IDLE;
                    if (done_reg)
                    begin
                        elapsed_next = '0;
                        moving_next  = 1'b0;
                    end
                    else
                    begin
                        elapsed_next = elapsed_sum[qbez_pkg::TIME_W]
                                     ? '1 : elapsed_sum[qbez_pkg::TIME_W-1:0];
                    end
                end
            end
            default:
            begin
                state_next = qbez_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= qbez_pkg::ST_IDLE;
            moving_reg   <= 1'b0;
            elapsed_reg  <= '0;
            total_reg    <= '0;
            lerp_go_reg  <= 1'b0;
            idx_reg      <= '0;
            step_reg     <= qbez_pkg::STEP_SC;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            moving_reg   <= moving_next;
            elapsed_reg  <= elapsed_next;
            total_reg    <= total_next;
            lerp_go_reg  <= lerp_go_next;
            idx_reg      <= idx_next;
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Pack the outgoing point, target on the final beat
    always_comb
    begin
        m_data_next = '0;
        for (int k = 0; k < qbez_pkg::NUM_AXES; k++)
        begin
            m_data_next[k * CW +: CW] = done_reg ? end_reg[k] : pos_reg[k];
        end
    end

    // Payload datapath
    always_ff @(posedge clk)
    begin
        if (start_acc)
        begin
            for (int k = 0; k < qbez_pkg::NUM_AXES; k++)
            begin
                start_reg[k] <= in_start[k];
                end_reg[k]   <= in_target[k];
            end
            half_reg  <= in_xdiff[CW:1];
            ahead_reg <= in_ahead;
        end
        if (state_reg == qbez_pkg::ST_CTRL)
        begin
            ctrl_reg[0] <= sat_add(start_reg[0], half_reg, !ahead_reg);
            ctrl_reg[1] <= sat_add(start_reg[1], half_reg, !ahead_reg);
            ctrl_reg[2] <= start_reg[2];
        end
        if (tick_acc)
        begin
            delta_reg <= in_delta;
            done_reg  <= !in_time;
        end
        if (div_res.valid)
        begin
            t_reg <= div_res.quot;
        end
        if (lerp_res.valid && state_reg == qbez_pkg::ST_LERP)
        begin
            case (step_reg)
                qbez_pkg::STEP_SC: a_reg <= lerp_res.value;
                qbez_pkg::STEP_CE: b_reg <= lerp_res.value;
                default:           pos_reg[idx_reg] <= lerp_res.value;
            endcase
        end
        if (emit_fire)
        begin
            m_tdata_reg <= m_data_next;
            m_tlast_reg <= done_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

[rtl/core/qbez_checker.sv]
// ---------------------------------------------------------------------------
// qbez_checker
// Port-level checks on the move generator, attached to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module qbez_checker
(
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic [0:0]                     s_tuser,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [qbez_pkg::M_DATA_W-1:0]  m_tdata,
    input wire logic                           m_tlast
);

    // Hold a stalled output beat
    `QB_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled output beat changed")

    // Drop ready for the cycle that derives the control point
    `QB_ASSERT(a_start_busy, s_tvalid && s_tready && s_tuser[0] == qbez_pkg::CMD_START |=> !s_tready, "ready held after start beat")

    // A new output beat only follows a cycle of work
    `QB_ASSERT(a_out_after_work, $rose(m_tvalid) |-> $past(!s_tready), "output beat appeared without work")

    // Keep the output empty once reset has been seen
    `QB_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !m_tvalid, "output valid during reset")

endmodule

bind quadratic_bezier_move_generator qbez_checker u_qbez_checker (.*);

`default_nettype wire

[test/quadratic_bezier_move_checker.sv]
// ---------------------------------------------------------------------------
// quadratic_bezier_move_checker
// Watches both stream channels of the Bezier move generator, predicts each
// curve point from the accepted input beats and compares the output beats.
// ---------------------------------------------------------------------------

module quadratic_bezier_move_checker
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    input  wire logic                              s_tready,
    // start_x, start_y, start_z, target_x, target_y, target_z, duration, delta_time
    input  wire logic [qbez_pkg::S_DATA_W-1:0]     s_tdata,
    // cmd
    input  wire logic [0:0]                        s_tuser,
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    // pos_x, pos_y, pos_z
    input  wire logic [qbez_pkg::M_DATA_W-1:0]     m_tdata,
    // done_res
    input  wire logic                              m_tlast,
    output int                                     fail_count,
    output int                                     pending
);

    import qbez_pkg::*;

    localparam int DUR_LSB     = 6 * COORD_W;
    localparam int DT_LSB      = DUR_LSB + TIME_W;
    localparam int PRINT_LIMIT = 20;
    localparam longint COORD_HI = (longint'(1) << (COORD_W - 1)) - 1;
    localparam longint COORD_LO = -(longint'(1) << (COORD_W - 1));

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
        logic   done;
    } path_point_t;

    // Points still owed by the block, oldest first
    path_point_t expected_points[$];

    // Shadow copy of the move state
    logic   moving;
    tick_t  elapsed_ticks;
    tick_t  move_ticks;
    coord_t from_pt[NUM_AXES];
    coord_t via_pt[NUM_AXES];
    coord_t to_pt[NUM_AXES];

    function automatic coord_t clamp_coord(input longint v);
        if (v > COORD_HI)
            return coord_t'(COORD_HI);
        if (v < COORD_LO)
            return coord_t'(COORD_LO);
        return coord_t'(v);
    endfunction

    // One interpolation step, rounding half up; the arithmetic shift floors
    function automatic longint blend(input longint p, input longint q, input longint t);
        longint prod;
        prod = (q - p) * t + (longint'(1) << (FRAC_W - 1));
        return p + (prod >>> FRAC_W);
    endfunction

    task automatic report_mismatch(input string msg);
        if (fail_count < PRINT_LIMIT)
            $display("mismatch: %s", msg);
        fail_count++;
    endtask

    // Advance the shadow state by one input beat and queue any point it owes
    task automatic predict_beat(input logic cmd, input logic [S_DATA_W-1:0] data);
        longint                  sx;
        longint                  tx;
        longint                  half;
        longint                  t;
        longint                  a;
        longint                  b;
        coord_t                  pt[NUM_AXES];
        logic [TIME_W+FRAC_W-1:0] num;
        logic [TIME_W:0]         sum;
        delta_t                  dt;
        path_point_t             res;
        if (cmd == CMD_START)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                from_pt[i] = data[i*COORD_W +: COORD_W];
                to_pt[i]   = data[(NUM_AXES+i)*COORD_W +: COORD_W];
            end
            move_ticks = data[DUR_LSB +: TIME_W];
            sx = longint'(from_pt[0]);
            tx = longint'(to_pt[0]);
            half = (tx > sx) ? (tx - sx) / 2 : -((sx - tx) / 2);
            via_pt[0] = clamp_coord(sx + half);
            via_pt[1] = clamp_coord(longint'(from_pt[1]) + half);
            via_pt[2] = from_pt[2];
            elapsed_ticks = '0;
            moving = 1'b1;
        end
        else if (moving)
        begin
            if (elapsed_ticks < move_ticks)
            begin
                num = {elapsed_ticks, {FRAC_W{1'b0}}};
                t = longint'(num / move_ticks);
                for (int i = 0; i < NUM_AXES; i++)
                begin
                    a = blend(longint'(from_pt[i]), longint'(via_pt[i]), t);
                    b = blend(longint'(via_pt[i]), longint'(to_pt[i]), t);
                    pt[i] = clamp_coord(blend(a, b, t));
                end
                res.x = pt[0];
                res.y = pt[1];
                res.z = pt[2];
                res.done = 1'b0;
                // Advance elapsed time, saturating at the top of the range
                dt = data[DT_LSB +: DELTA_W];
                sum = elapsed_ticks + dt;
                elapsed_ticks = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
            end
            else
            begin
                res.x = to_pt[0];
                res.y = to_pt[1];
                res.z = to_pt[2];
                res.done = 1'b1;
                elapsed_ticks = '0;
                moving = 1'b0;
            end
            expected_points.push_back(res);
        end
    endtask

    task automatic check_point();
        path_point_t exp_pt;
        coord_t      got_x;
        coord_t      got_y;
        coord_t      got_z;
        if (expected_points.size() == 0)
        begin
            report_mismatch("output beat with no point expected");
            return;
        end
        exp_pt = expected_points.pop_front();
        got_x = m_tdata[0 +: COORD_W];
        got_y = m_tdata[COORD_W +: COORD_W];
        got_z = m_tdata[2*COORD_W +: COORD_W];
        if (got_x !== exp_pt.x)
            report_mismatch($sformatf("pos_x %0d, expected %0d", got_x, exp_pt.x));
        if (got_y !== exp_pt.y)
            report_mismatch($sformatf("pos_y %0d, expected %0d", got_y, exp_pt.y));
        if (got_z !== exp_pt.z)
            report_mismatch($sformatf("pos_z %0d, expected %0d", got_z, exp_pt.z));
        if (m_tlast !== exp_pt.done)
            report_mismatch($sformatf("done %0b, expected %0b", m_tlast, exp_pt.done));
    endtask

    // Compare output beats before queueing new points from input beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            moving = 1'b0;
            elapsed_ticks = '0;
            move_ticks = '0;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                from_pt[i] = '0;
                via_pt[i] = '0;
                to_pt[i] = '0;
            end
            expected_points.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_point();
            if (s_tvalid && s_tready)
                predict_beat(s_tuser[0], s_tdata);
            pending = expected_points.size();
        end
    end

endmodule

[test/tb.sv]
// ---------------------------------------------------------------------------
// tb
// Stimulus for the quadratic Bezier move generator: directed moves covering
// the corner cases, then random move sequences under three idling phases.
// ---------------------------------------------------------------------------

module tb;

    import qbez_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES  = 600;
    localparam coord_t C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam tick_t  T_MAX = '1;
    localparam delta_t D_MAX = '1;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [0:0]          s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;
    int                  fail_count;
    int                  pending;

    int phase      = 0;
    bit hold_req   = 1'b0;
    int beats_sent = 0;
    int cycles     = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    quadratic_bezier_move_generator u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    quadratic_bezier_move_checker u_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Abort a run that hangs
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int tx_idle_pct();
        case (phase)
            1: return 6;
            2: return 83;
            default: return 0;
        endcase
    endfunction

    function automatic int rx_idle_pct();
        case (phase)
            1: return 83;
            2: return 6;
            default: return 0;
        endcase
    endfunction

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int hold_left;
        bit hold_taken;
        hold_left = 0;
        hold_taken = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_left = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct());
        end
    end

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 7))
            0: return coord_t'($urandom);
            1: return C_MAX;
            2: return C_MIN;
            default: return coord_t'($urandom_range(0, 8191) - 4096);
        endcase
    endfunction

    // Offer one beat after a random gap and hold it until taken
    task automatic send_beat(input logic cmd, input coord_t sx, input coord_t sy,
                             input coord_t sz, input coord_t tx, input coord_t ty,
                             input coord_t tz, input tick_t dur, input delta_t dt);
        while ($urandom_range(0, 99) < tx_idle_pct())
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {dt, dur, tz, ty, tx, sz, sy, sx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        beats_sent++;
    endtask

    task automatic start_move(input coord_t sx, input coord_t sy, input coord_t sz,
                              input coord_t tx, input coord_t ty, input coord_t tz,
                              input tick_t dur);
        send_beat(CMD_START, sx, sy, sz, tx, ty, tz, dur, delta_t'($urandom));
    endtask

    // Unused fields of a tick carry random bits
    task automatic tick(input delta_t dt);
        send_beat(CMD_TICK, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                  tick_t'($urandom), dt);
    endtask

    // Stop offering and wait for every owed point
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // A start followed by a run of ticks, mostly short moves that finish
    task automatic run_move();
        int     scale;
        int     ticks;
        tick_t  dur;
        delta_t dmax;
        scale = $urandom_range(0, 9);
        if (scale < 7)
        begin
            dur = $urandom_range(0, 40);
            dmax = 8;
        end
        else if (scale < 9)
        begin
            dur = $urandom_range(0, 5000);
            dmax = 1000;
        end
        else
        begin
            dur = tick_t'($urandom);
            dmax = D_MAX;
        end
        start_move(rand_coord(), rand_coord(), rand_coord(),
                   rand_coord(), rand_coord(), rand_coord(), dur);
        ticks = $urandom_range(1, 20);
        repeat (ticks)
        begin
            if ($urandom_range(0, 15) == 0)
                tick(delta_t'($urandom));
            else
                tick(delta_t'($urandom_range(0, dmax)));
        end
    endtask

    task automatic random_phase(input int upto);
        int kind;
        while (beats_sent < upto)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 8)
                run_move();
            else if (kind == 8)
            begin
                // Noise: random command with random fields
                repeat ($urandom_range(1, 3))
                    send_beat(logic'($urandom_range(0, 1)), coord_t'($urandom),
                              coord_t'($urandom), coord_t'($urandom),
                              coord_t'($urandom), coord_t'($urandom),
                              coord_t'($urandom), tick_t'($urandom),
                              delta_t'($urandom));
            end
            else
            begin
                // Broken sequence: ticks with no fresh start
                repeat ($urandom_range(1, 4))
                    tick(delta_t'($urandom_range(0, 16)));
            end
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        phase = 1;
        // Tick while idle
        tick(delta_t'($urandom));
        // Zero duration: first tick returns the target, next tick is idle
        start_move(C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, '0);
        tick(16'd1);
        tick(16'd5);
        // Target ahead, control Y saturates high; zero and full deltas
        start_move(C_MIN, C_MAX, '0, C_MAX, '0, C_MAX, 24'd4);
        tick(16'd1);
        tick('0);
        tick(16'd2);
        tick(D_MAX);
        tick(16'd1);
        // Target behind, control Y saturates low, longest duration
        start_move(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, T_MAX);
        tick(D_MAX);
        tick(D_MAX);
        // Restart mid-move with equal X coordinates
        start_move(24'sd1234, -24'sd5, 24'sd7, 24'sd1234, 24'sd100, -24'sd100, 24'd3);
        repeat (4) tick(16'd1);
        // One-tick move overshot by a full delta
        start_move(rand_coord(), rand_coord(), rand_coord(),
                   rand_coord(), rand_coord(), rand_coord(), 24'd1);
        tick(D_MAX);
        tick('0);
        tick('0);

        random_phase(500);
        drain();

        phase = 2;
        random_phase(1000);
        drain();

        phase = 3;
        hold_req = 1'b1;
        random_phase(1100);
        // Full-length move: elapsed time runs into saturation
        start_move(rand_coord(), rand_coord(), rand_coord(),
                   rand_coord(), rand_coord(), rand_coord(), T_MAX);
        repeat (259) tick(D_MAX);
        random_phase(1560);
        drain();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/qbez_pkg.sv
rtl/core/qbez_div.sv
rtl/core/qbez_lerp.sv
rtl/core/quadratic_bezier_move_generator.sv
rtl/core/qbez_checker.sv
test/quadratic_bezier_move_checker.sv
test/tb.sv
